// ===== rtl/lmts_pkg.sv =====
// shared types, font tables and codes for the led matrix text scroller
package lmts_pkg;

    localparam int FONT_SIZE   = 37;
    localparam int GLYPH_W     = 6;
    localparam int LEN_W       = 7;
    localparam int REPEAT_W    = 16;
    localparam int STEP_W      = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [GLYPH_W-1:0] SPACE_GLYPH = 6'd26;

    localparam logic [CFG_INDEX_W-1:0] CFG_MESSAGE_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFRESH_REPEATS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_MODE    = 2'd2;

    localparam logic [REPEAT_W-1:0] REPEATS_RESET = 16'd250;

    localparam logic MODE_GLYPH  = 1'b0;
    localparam logic MODE_SCROLL = 1'b1;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_TICK  = 1'b1;

    localparam logic [15:0] FONT_CODES [FONT_SIZE] = '{
        16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E,
        16'h004F, 16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055,
        16'h0056, 16'h0057, 16'h0058, 16'h0059, 16'h005A, 16'h0020, 16'h0104,
        16'h0106, 16'h0118, 16'h0141, 16'h0143, 16'h00D3, 16'h015A, 16'h0179,
        16'h017B, 16'h0000
    };

    // column c of a glyph sits in byte c
    localparam logic [63:0] FONT_COLS [FONT_SIZE] = '{
        64'h0000FE111111FE00, 64'h00006E919191FF00, 64'h0000668181817E00,
        64'h00007E818181FF00, 64'h000081919191FF00, 64'h000001111111FF00,
        64'h00007A8981817E00, 64'h0000FF101010FF00, 64'h00008181FF818100,
        64'h00007F8181806000, 64'h000083442810FF00, 64'h000080808080FF00,
        64'h0000FF083008FF00, 64'h0000FF201008FF00, 64'h00007E8181817E00,
        64'h00000E111111FF00, 64'h0000FF8581817E00, 64'h00008E513111FF00,
        64'h0000629191914E00, 64'h00000101FF010100, 64'h00007F8080807F00,
        64'h00003F4080403F00, 64'h0000FF403840FF00, 64'h0000C3241824C300,
        64'h00000F10E0100F00, 64'h0000878991A1C100, 64'h0000000000000000,
        64'h00C07E1111117E00, 64'h01804C8282827C00, 64'h000041D151517F00,
        64'h0000808C9888FF00, 64'h0102FF040810FF00, 64'h01807C8282827C00,
        64'h0000649392924C00, 64'h0000868B92A2C200, 64'h000042474B526200,
        64'h0000000000000000
    };

    typedef struct packed {
        logic       glyph_ok;
        logic [2:0] glyph_col;
        logic [2:0] column;
    } tick_t;

    function automatic logic [GLYPH_W-1:0] code_to_glyph(input logic [15:0] code);
        logic [GLYPH_W-1:0] glyph;
        logic               found;
        glyph = SPACE_GLYPH;
        found = 1'b0;
        for (int i = 0; i < FONT_SIZE; i++)
        begin
            if (!found && FONT_CODES[i] == code)
            begin
                glyph = GLYPH_W'(i);
                found = 1'b1;
            end
        end
        return glyph;
    endfunction

endpackage

// ===== rtl/lmts_in_if.sv =====
// input channel: write and tick items
interface lmts_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [5:0]  char_position;
    logic [15:0] char_code;

    modport source (output valid, output action, output char_position, output char_code,
                    input ready);
    modport sink (input valid, input action, input char_position, input char_code,
                  output ready);
endinterface

// ===== rtl/lmts_out_if.sv =====
// output channel: column drive results
interface lmts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] row_bits;
    logic [2:0] column_select;

    modport source (output valid, output row_bits, output column_select, input ready);
    modport sink (input valid, input row_bits, input column_select, output ready);
endinterface

// ===== rtl/lmts_ram.sv =====
// generic single write port ram with registered read
module lmts_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/led_matrix_text_scroller_top.sv =====
// top level of the led matrix text scroller
// a tick transfer reads the glyph ram in the font stage; the font lookup fills the output register
// throughput: one item per cycle; the output register lets a new item enter while a
// result waits, and input stalls only when the font stage and output are full and out_ch.ready is low
// reset: counters, scroll position, configuration and valid flags return to defaults; the
// glyph ram is not cleared; the user must write entries before ticks read them; the block does not enforce it
module led_matrix_text_scroller_top #(
    parameter int MESSAGE_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lmts_in_if.sink                             in_ch,
    lmts_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [lmts_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lmts_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(MESSAGE_DEPTH);
    localparam int POS_W  = (MESSAGE_DEPTH >= 128) ? lmts_pkg::STEP_W
                                                   : $clog2(MESSAGE_DEPTH * 8);

    logic [lmts_pkg::LEN_W-1:0]    message_length_reg;
    logic [lmts_pkg::REPEAT_W-1:0] refresh_repeats_reg;
    logic                          display_mode_reg;

    logic [POS_W-1:0]              scroll_position_reg;
    logic [POS_W-1:0]              scroll_position_next;
    logic [2:0]                    column_counter_reg;
    logic [lmts_pkg::REPEAT_W-1:0] repeat_counter_reg;

    logic                          s1_valid_reg;
    lmts_pkg::tick_t               s1_reg;
    lmts_pkg::tick_t               s1_next;

    logic                          out_valid_reg;
    logic [7:0]                    row_bits_reg;
    logic [7:0]                    row_bits_next;
    logic [2:0]                    column_select_reg;

    logic                          in_accept;
    logic                          tick_acc;
    logic                          wr_acc;
    logic                          slot_ok;
    logic                          s1_advance;

    logic [lmts_pkg::LEN_W-1:0]    len_eff;
    logic [lmts_pkg::LEN_W-1:0]    glyph_cnt;
    logic [lmts_pkg::STEP_W-1:0]   steps;
    logic [lmts_pkg::STEP_W-1:0]   pos_cur;
    logic [lmts_pkg::STEP_W:0]     pos_inc;
    logic [lmts_pkg::STEP_W-1:0]   pos_wrap;
    logic [3:0]                    col_sum;
    logic [7:0]                    glyph_idx;
    logic [lmts_pkg::REPEAT_W-1:0] limit;
    logic [lmts_pkg::REPEAT_W-1:0] repeat_inc;

    logic [ADDR_W-1:0]             waddr;
    logic [ADDR_W-1:0]             raddr;
    logic [lmts_pkg::GLYPH_W-1:0]  wglyph;
    logic [lmts_pkg::GLYPH_W-1:0]  rglyph;
    logic [63:0]                   glyph_cols;

    assign s1_advance   = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || !out_valid_reg || out_ch.ready;
    assign in_accept    = in_ch.valid && in_ch.ready;
    assign tick_acc     = in_accept && (in_ch.action == lmts_pkg::ACTION_TICK);
    assign wr_acc       = in_accept && (in_ch.action == lmts_pkg::ACTION_WRITE);
    assign slot_ok      = 32'(in_ch.char_position) < 32'(MESSAGE_DEPTH);
    assign waddr        = ADDR_W'(32'(in_ch.char_position));
    assign wglyph       = lmts_pkg::code_to_glyph(in_ch.char_code);

    // view position and glyph address for the current tick, plus next scroll position and repeat limit
    always_comb
    begin
        len_eff   = (32'(message_length_reg) > 32'(MESSAGE_DEPTH))
                    ? lmts_pkg::LEN_W'(MESSAGE_DEPTH) : message_length_reg;
        glyph_cnt = (len_eff == '0) ? lmts_pkg::LEN_W'(1) : len_eff;
        steps     = (display_mode_reg == lmts_pkg::MODE_SCROLL)
                    ? {glyph_cnt, 3'b000} : {3'b000, glyph_cnt};
        pos_cur   = (lmts_pkg::STEP_W'(scroll_position_reg) >= steps)
                    ? '0 : lmts_pkg::STEP_W'(scroll_position_reg);
        col_sum   = {1'b0, pos_cur[2:0]} + {1'b0, column_counter_reg};
        if (display_mode_reg == lmts_pkg::MODE_SCROLL)
        begin
            glyph_idx         = {1'b0, pos_cur[9:3]} + {7'd0, col_sum[3]};
            s1_next.glyph_col = col_sum[2:0];
        end
        else
        begin
            glyph_idx         = {1'b0, pos_cur[6:0]};
            s1_next.glyph_col = column_counter_reg;
        end
        s1_next.glyph_ok = (len_eff != '0) && (glyph_idx < {1'b0, len_eff});
        s1_next.column   = column_counter_reg;
        raddr            = ADDR_W'(32'(glyph_idx));

        pos_inc              = {1'b0, pos_cur} + 11'd1;
        pos_wrap             = (pos_inc >= {1'b0, steps})
                               ? '0 : pos_inc[lmts_pkg::STEP_W-1:0];
        scroll_position_next = POS_W'(pos_wrap);
        limit                = (refresh_repeats_reg == '0)
                               ? lmts_pkg::REPEAT_W'(1) : refresh_repeats_reg;
        repeat_inc           = repeat_counter_reg + lmts_pkg::REPEAT_W'(1);
    end

    lmts_ram #(
        .WIDTH (lmts_pkg::GLYPH_W),
        .DEPTH (MESSAGE_DEPTH)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (wr_acc && slot_ok),
        .waddr (waddr),
        .wdata (wglyph),
        .re    (tick_acc),
        .raddr (raddr),
        .rdata (rglyph)
    );

    always_comb
    begin
        glyph_cols    = '0;
        row_bits_next = 8'd0;
        if (s1_reg.glyph_ok && (32'(rglyph) < 32'(lmts_pkg::FONT_SIZE)))
        begin
            glyph_cols    = lmts_pkg::FONT_COLS[rglyph];
            row_bits_next = glyph_cols[{s1_reg.glyph_col, 3'b000} +: 8];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            message_length_reg  <= '0;
            refresh_repeats_reg <= lmts_pkg::REPEATS_RESET;
            display_mode_reg    <= lmts_pkg::MODE_SCROLL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lmts_pkg::CFG_MESSAGE_LENGTH:  message_length_reg  <= cfg_data[6:0];
                lmts_pkg::CFG_REFRESH_REPEATS: refresh_repeats_reg <= cfg_data;
                lmts_pkg::CFG_DISPLAY_MODE:    display_mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // multiplex counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_position_reg <= '0;
            column_counter_reg  <= '0;
            repeat_counter_reg  <= '0;
        end
        else if (tick_acc)
        begin
            column_counter_reg <= column_counter_reg + 3'd1;
            if (column_counter_reg == 3'd7)
            begin
                if (repeat_inc >= limit)
                begin
                    repeat_counter_reg  <= '0;
                    scroll_position_reg <= scroll_position_next;
                end
                else
                begin
                    repeat_counter_reg <= repeat_inc;
                end
            end
        end
    end

    // font stage and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            s1_reg <= s1_next;
        end
        if (s1_advance)
        begin
            row_bits_reg      <= row_bits_next;
            column_select_reg <= s1_reg.column;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.row_bits      = row_bits_reg;
    assign out_ch.column_select = column_select_reg;

    a_tick_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc |=> s1_valid_reg)
        else $error("tick transfer did not reach the font stage");

    a_column_steps: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc |=> column_counter_reg == $past(column_counter_reg) + 3'd1)
        else $error("column counter did not advance on a tick");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=>
            (out_valid_reg && $stable(row_bits_reg) && $stable(column_select_reg)))
        else $error("stalled result changed");

endmodule
